/* rtl/core/u8gp_pkg.sv */
// ----------------------------------------------------------------------------
// u8gp_pkg
// Shared types, constants and the character-to-glyph map of the glyph placer.
// ----------------------------------------------------------------------------
package u8gp_pkg;

    localparam int unsigned GLYPH_COUNT       = 100;
    localparam int unsigned GLYPH_SIZE        = 8;
    localparam int unsigned QUEUE_DEPTH_DFLT  = 4;

    localparam logic [7:0] WIDTH_RST          = 8'd128;
    localparam logic [7:0] HEIGHT_RST         = 8'd64;

    // configuration register indexes
    localparam logic CFG_DISPLAY_WIDTH        = 1'b0;
    localparam logic CFG_DISPLAY_HEIGHT       = 1'b1;

    // UTF-8 byte classes
    localparam logic [2:0] LEAD2_PREFIX       = 3'b110;

    // glyph map layout
    localparam int unsigned SYM_COUNT         = 37;
    localparam logic [6:0]  UPPER_BASE        = 7'd1;
    localparam logic [6:0]  DIGIT_BASE        = 7'd27;
    localparam logic [6:0]  LOWER_BASE        = 7'd37;
    localparam logic [6:0]  SYM_BASE          = 7'd63;

    localparam logic [7:0] SYM_CODES [SYM_COUNT] = '{
        8'h2E, 8'h3A, 8'h23, 8'h21, 8'h3F, 8'hC3, 8'hC2, 8'hC1, 8'hC0, 8'hC9,
        8'hCA, 8'hCD, 8'hD3, 8'hD4, 8'hD5, 8'hDA, 8'hC7, 8'hE7, 8'hE3, 8'hE1,
        8'hE0, 8'hE2, 8'hE9, 8'hEA, 8'hED, 8'hF3, 8'hF4, 8'hFA, 8'h2C, 8'h2A,
        8'h2D, 8'h5F, 8'hBA, 8'h2F, 8'hB2, 8'h28, 8'h29
    };

    // one queued placement: text row, pixel column and Latin-1 code
    typedef struct packed {
        logic [5:0] row;
        logic [7:0] col;
        logic [7:0] code;
    } place_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic [6:0] glyph_of(input logic [7:0] c);
        logic [6:0] g;
        g = '0;
        case (c) inside
            [8'h41:8'h5A]: g = 7'(c - 8'h41) + UPPER_BASE;
            [8'h30:8'h39]: g = 7'(c - 8'h30) + DIGIT_BASE;
            [8'h61:8'h7A]: g = 7'(c - 8'h61) + LOWER_BASE;
            default: begin
                // table codes are distinct, so at most one matches
                for (int i = 0; i < SYM_COUNT; i++) begin
                    if (SYM_CODES[i] == c) begin
                        g = SYM_BASE + 7'(i);
                    end
                end
            end
        endcase
        if (32'(g) >= GLYPH_COUNT) begin
            g = '0;
        end
        return g;
    endfunction

endpackage

/* rtl/core/u8gp_front.sv */
// ----------------------------------------------------------------------------
// u8gp_front
// Accepts text bytes, decodes UTF-8 pairs, keeps the cursor and queues a
// placement for every glyph that fits on the display.
// ----------------------------------------------------------------------------
module u8gp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          display_width,
    input  logic [7:0]          display_height,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_text_byte,
    input  logic                s_first_byte,
    input  logic [7:0]          s_start_x,
    input  logic [7:0]          s_start_y,
    input  u8gp_pkg::qstat_t    q_stat,
    output logic                push,
    output u8gp_pkg::place_t    push_data
);

    localparam logic [9:0] GSIZE = 10'(u8gp_pkg::GLYPH_SIZE);

    logic [8:0] cursor_x_reg, cursor_x_next;
    logic [8:0] cursor_y_reg, cursor_y_next;
    logic       lead_pending_reg, lead_pending_next;
    logic [1:0] lead_bits_reg, lead_bits_next;
    logic       string_done_reg, string_done_next;

    logic [8:0] cx_cur, cy_cur, cx_adv, cy_adv;
    logic       lp_cur, done_cur;
    logic [1:0] lb_cur;
    logic       draw, emit;
    logic [7:0] code;
    logic       accept;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cx_cur   = s_first_byte ? {1'b0, s_start_x} : cursor_x_reg;
        cy_cur   = s_first_byte ? {1'b0, s_start_y} : cursor_y_reg;
        lp_cur   = s_first_byte ? 1'b0 : lead_pending_reg;
        lb_cur   = s_first_byte ? 2'b00 : lead_bits_reg;
        done_cur = s_first_byte ? 1'b0 : string_done_reg;

        cursor_x_next     = cx_cur;
        cursor_y_next     = cy_cur;
        lead_pending_next = lp_cur;
        lead_bits_next    = lb_cur;
        string_done_next  = done_cur;
        draw              = 1'b0;
        code              = s_text_byte;
        cx_adv            = cx_cur + 9'(u8gp_pkg::GLYPH_SIZE);
        cy_adv            = cy_cur;

        if (!done_cur) begin
            if (({1'b0, cy_cur} + GSIZE > {2'b00, display_height}) ||
                (s_text_byte == 8'h00)) begin
                string_done_next  = 1'b1;
                lead_pending_next = 1'b0;
                lead_bits_next    = 2'b00;
            end else if (lp_cur) begin
                // only the low two lead bits survive the 8-bit code
                code              = {lb_cur, s_text_byte[5:0]};
                lead_pending_next = 1'b0;
                lead_bits_next    = 2'b00;
                draw              = 1'b1;
            end else if (!s_text_byte[7]) begin
                draw = 1'b1;
            end else if (s_text_byte[7:5] == u8gp_pkg::LEAD2_PREFIX) begin
                lead_pending_next = 1'b1;
                lead_bits_next    = s_text_byte[1:0];
            end
        end

        if (draw) begin
            // wrap when the advanced cursor no longer leaves room for a glyph
            if ({1'b0, cx_adv} + GSIZE > {2'b00, display_width}) begin
                cx_adv = '0;
                cy_adv = cy_cur + 9'(u8gp_pkg::GLYPH_SIZE);
            end
            cursor_x_next = cx_adv;
            cursor_y_next = cy_adv;
            if ({1'b0, cy_adv} + GSIZE > {2'b00, display_height}) begin
                string_done_next = 1'b1;
            end
        end
    end

    assign emit = draw && ({1'b0, cx_cur} + GSIZE <= {2'b00, display_width});
    assign push = accept && emit;

    always_comb begin
        push_data.row  = cy_cur[8:3];
        push_data.col  = cx_cur[7:0];
        push_data.code = code;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            lead_pending_reg <= 1'b0;
            lead_bits_reg    <= '0;
            string_done_reg  <= 1'b1;
        end else if (accept) begin
            cursor_x_reg     <= cursor_x_next;
            cursor_y_reg     <= cursor_y_next;
            lead_pending_reg <= lead_pending_next;
            lead_bits_reg    <= lead_bits_next;
            string_done_reg  <= string_done_next;
        end
    end

endmodule

/* rtl/core/u8gp_queue.sv */
// ----------------------------------------------------------------------------
// u8gp_queue
// Short register FIFO of placements between the decoder and the output side.
// ----------------------------------------------------------------------------
module u8gp_queue #(
    parameter int unsigned DEPTH = u8gp_pkg::QUEUE_DEPTH_DFLT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  u8gp_pkg::place_t    push_data,
    input  logic                pop,
    output u8gp_pkg::place_t    head,
    output u8gp_pkg::qstat_t    q_stat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    u8gp_pkg::place_t mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/u8gp_back.sv */
// ----------------------------------------------------------------------------
// u8gp_back
// Turns a queued placement into a framebuffer index and glyph index and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module u8gp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          display_width,
    input  u8gp_pkg::qstat_t    q_stat,
    input  u8gp_pkg::place_t    head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [12:0]         m_fb_index,
    output logic [6:0]          m_glyph_index
);

    logic        out_valid_reg;
    logic [12:0] fb_index_reg;
    logic [6:0]  glyph_index_reg;
    logic [13:0] row_base;
    logic [14:0] fb_sum;

    assign pop      = !q_stat.empty && (!out_valid_reg || m_ready);
    assign row_base = head.row * display_width;
    // skip the display control byte
    assign fb_sum   = {1'b0, row_base} + 15'(head.col) + 15'd1;

    always_ff @(posedge aclk) begin
        if (pop) begin
            fb_index_reg    <= fb_sum[12:0];
            glyph_index_reg <= u8gp_pkg::glyph_of(head.code);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_fb_index    = fb_index_reg;
    assign m_glyph_index = glyph_index_reg;

endmodule

/* rtl/core/utf8_text_glyph_placer_top.sv */
// ----------------------------------------------------------------------------
// utf8_text_glyph_placer_top
// Places glyphs of a UTF-8 text stream on a byte-organized display.
// ----------------------------------------------------------------------------
// Input channel (s_*): one text byte per item; s_first_byte starts a string
// at (s_start_x, s_start_y). A zero byte or running off the bottom ends it.
// Result channel (m_*): one item per drawn glyph, giving the framebuffer byte
// index and the font entry. Lead bytes, dropped bytes and glyphs that do not
// fit give no result. Configuration: cfg_wr_en writes cfg_wdata to the width
// (cfg_addr 0) or height (cfg_addr 1) register; write only while idle.
// Throughput: one byte per cycle while s_ready is high. The decoder and cursor
// update in the cycle the byte is accepted; the placement then waits in a
// QUEUE_DEPTH-entry FIFO. Path: a result passes from its FIFO entry into the
// output register; the framebuffer multiply and glyph lookup lie between the
// FIFO head and the output register.
// Stall: with m_ready low the output register holds, the FIFO fills, and
// s_ready drops once the FIFO is full.
// Reset: cursor at 0,0, no string active, width 128, height 64, FIFO empty.
// ----------------------------------------------------------------------------
module utf8_text_glyph_placer_top #(
    parameter int unsigned QUEUE_DEPTH = u8gp_pkg::QUEUE_DEPTH_DFLT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_first_byte,
    input  logic [7:0]  s_start_x,
    input  logic [7:0]  s_start_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [12:0] m_fb_index,
    output logic [6:0]  m_glyph_index
);

    logic [7:0]        display_width_reg;
    logic [7:0]        display_height_reg;
    logic              push, pop;
    u8gp_pkg::place_t  push_data, head;
    u8gp_pkg::qstat_t  q_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            display_width_reg  <= u8gp_pkg::WIDTH_RST;
            display_height_reg <= u8gp_pkg::HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                u8gp_pkg::CFG_DISPLAY_WIDTH:  display_width_reg  <= cfg_wdata;
                u8gp_pkg::CFG_DISPLAY_HEIGHT: display_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    u8gp_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .display_width  (display_width_reg),
        .display_height (display_height_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .s_first_byte   (s_first_byte),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .q_stat         (q_stat),
        .push           (push),
        .push_data      (push_data)
    );

    u8gp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    u8gp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .display_width (display_width_reg),
        .q_stat        (q_stat),
        .head          (head),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_fb_index    (m_fb_index),
        .m_glyph_index (m_glyph_index)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("placement pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("placement popped from an empty queue");

    a_glyph_in_font: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_glyph_index) < u8gp_pkg::GLYPH_COUNT))
        else $error("glyph index beyond the font table");

    a_result_follows_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid)) |-> $past(pop))
        else $error("result appeared without a queued placement");

endmodule
